// ===== rtl/sqp_pkg.sv =====
// ----------------------------------------------------------------------------
// sqp_pkg: shared types and constants
// Command kinds, result codes, register indexes and fixed field widths for
// the submission/completion ring pair.
// ----------------------------------------------------------------------------
package sqp_pkg;

	localparam int KIND_W   = 2;
	localparam int CODE_W   = 3;
	localparam int TAG_W    = 32;
	localparam int STAT_W   = 16;
	localparam int BYTES_W  = 32;
	localparam int REQ_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// status value that marks a slot as holding no record
	localparam logic [STAT_W-1:0] SLOT_EMPTY = 16'hFFFF;
	// depth used when a request of zero is written
	localparam logic [REQ_W-1:0] DEFAULT_DEPTH = 8'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_SUBMIT = 2'd0,
		KIND_POST   = 2'd1,
		KIND_TAKE   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [CODE_W-1:0] {
		RC_OK        = 3'd0,
		RC_FULL      = 3'd1,
		RC_NOT_READY = 3'd2,
		RC_EMPTY     = 3'd3,
		RC_TAG_MISS  = 3'd4,
		RC_BAD_STAT  = 3'd5
	} result_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 2'd0,
		REG_SUBMIT_DEP = 2'd1,
		REG_COMP_DEP   = 2'd2,
		REG_OK_STATUS  = 2'd3
	} cfg_index_t;

endpackage

// ===== rtl/submit_completion_queue_pair.sv =====
// ----------------------------------------------------------------------------
// submit_completion_queue_pair: submission / completion ring tracker
// Keeps the pointers of a submission ring and a completion ring together
// with the completion records, and answers one result for every request.
// ----------------------------------------------------------------------------
// Timing: a request is registered at the edge where start is high and busy
// is low and handled in the following cycle. Its result goes onto the result
// ports with result_valid at the next edge and stays for exactly one cycle.
// A new request can be taken every cycle while busy is low; the input
// register and the result register are the only stages and all pointer
// and slot updates complete between them, so back-to-back requests always
// see the state left by the one before. busy is high while reset is applied
// and is cleared at the first clock edge after it is released. The receiver
// cannot stall: a result not captured in its cycle is gone. Configuration
// writes are taken in any cycle but must only
// be issued while no request is in flight. Ring depths are clamped: zero
// selects 4, values above MAX_RING_DEPTH select MAX_RING_DEPTH, and others are
// rounded down to a power of two; one submission slot is always kept free.
// Posting a status of 16'hFFFF leaves the slot reading as empty.
module submit_completion_queue_pair
	import sqp_pkg::*;
#(
	parameter int MAX_RING_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  start,
	output logic                  busy,
	input  logic [KIND_W-1:0]     kind,
	input  logic [TAG_W-1:0]      item_tag,
	input  logic [STAT_W-1:0]     comp_status,
	input  logic [STAT_W-1:0]     comp_ext_status,
	input  logic [BYTES_W-1:0]    comp_bytes,
	// configuration write port
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// result channel
	output logic                  result_valid,
	output logic [CODE_W-1:0]     result_code,
	output logic [TAG_W-1:0]      out_tag,
	output logic [STAT_W-1:0]     out_status,
	output logic [STAT_W-1:0]     out_ext_status,
	output logic [BYTES_W-1:0]    out_bytes
);

	localparam int PW = (MAX_RING_DEPTH > 1) ? $clog2(MAX_RING_DEPTH) : 1;
	localparam int DW = REQ_W + 1;  // clamped depth, holds 256
	localparam logic [DW-1:0] MAX_D = DW'(MAX_RING_DEPTH);

	// ---------------- configuration registers ----------------
	logic              enable_q;
	logic [REQ_W-1:0]  sub_req_q;
	logic [REQ_W-1:0]  comp_req_q;
	logic [STAT_W-1:0] ok_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			sub_req_q   <= DEFAULT_DEPTH;
			comp_req_q  <= DEFAULT_DEPTH;
			ok_status_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				REG_ENABLE:     enable_q    <= cfg_data[0];
				REG_SUBMIT_DEP: sub_req_q   <= cfg_data[REQ_W-1:0];
				REG_COMP_DEP:   comp_req_q  <= cfg_data[REQ_W-1:0];
				REG_OK_STATUS:  ok_status_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Depth mask: clamp, then floor to a power of two minus one by smearing
	// the top set bit downward and dropping the lowest position.
	function automatic logic [PW-1:0] depth_mask(input logic [REQ_W-1:0] req);
		logic [DW-1:0] d;
		logic [DW-1:0] s;
		begin
			d = (req == '0) ? DW'(DEFAULT_DEPTH) : DW'(req);
			if (d > MAX_D)
				d = MAX_D;
			s = d | (d >> 1);
			s = s | (s >> 2);
			s = s | (s >> 4);
			s = s | (s >> 8);
			s = s >> 1;
			depth_mask = s[PW-1:0];
		end
	endfunction

	logic [PW-1:0] smask, cmask;
	assign smask = depth_mask(sub_req_q);
	assign cmask = depth_mask(comp_req_q);

	// ---------------- start-up hold ----------------
	logic busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end
	assign busy = busy_q;

	logic accept;
	assign accept = start && !busy_q;

	// ---------------- input register ----------------
	logic               valid_s1;
	kind_t              kind_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [STAT_W-1:0]  stat_s1;
	logic [STAT_W-1:0]  ext_s1;
	logic [BYTES_W-1:0] bytes_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_t'(kind);
			tag_s1   <= item_tag;
			stat_s1  <= comp_status;
			ext_s1   <= comp_ext_status;
			bytes_s1 <= comp_bytes;
		end
	end

	// ---------------- ring state ----------------
	logic [PW-1:0] sub_head_q, sub_tail_q, comp_head_q, comp_tail_q;
	// occupied bit per completion slot; a clear slot reads as empty, so the
	// record stores themselves need no reset
	logic [MAX_RING_DEPTH-1:0] occ_q;
	logic [TAG_W-1:0]   tag_mem_q   [MAX_RING_DEPTH];
	logic [STAT_W-1:0]  stat_mem_q  [MAX_RING_DEPTH];
	logic [STAT_W-1:0]  ext_mem_q   [MAX_RING_DEPTH];
	logic [BYTES_W-1:0] bytes_mem_q [MAX_RING_DEPTH];

	// masked pointers; a depth change mid-use simply folds them
	logic [PW-1:0] sh_m, st_m, ch_m, ct_m;
	assign sh_m = sub_head_q & smask;
	assign st_m = sub_tail_q & smask;
	assign ch_m = comp_head_q & cmask;
	assign ct_m = comp_tail_q & cmask;

	logic [PW-1:0] sub_next, sub_tail_next, comp_head_next, comp_tail_next;
	assign sub_next       = (sh_m + PW'(1)) & smask;
	assign sub_tail_next  = (st_m + PW'(1)) & smask;
	assign comp_head_next = (ch_m + PW'(1)) & cmask;
	assign comp_tail_next = (ct_m + PW'(1)) & cmask;

	logic head_occ;
	assign head_occ = occ_q[ch_m];

	// ---------------- single-pass decode ----------------
	logic               do_sub, do_post, do_pop, do_clear;
	result_code_t       code_d;
	logic [TAG_W-1:0]   otag_d;
	logic [STAT_W-1:0]  ostat_d, oext_d;
	logic [BYTES_W-1:0] obytes_d;

	always_comb begin
		do_sub   = 1'b0;
		do_post  = 1'b0;
		do_pop   = 1'b0;
		do_clear = 1'b0;
		code_d   = RC_OK;
		otag_d   = '0;
		ostat_d  = '0;
		oext_d   = '0;
		obytes_d = '0;
		if (valid_s1) begin
			case (kind_s1)
				KIND_SUBMIT: begin
					if (!enable_q)
						code_d = RC_NOT_READY;
					else if (sub_next == st_m)
						code_d = RC_FULL;
					else
						do_sub = 1'b1;
				end
				KIND_POST: do_post = 1'b1;
				KIND_TAKE: begin
					if (!head_occ) begin
						code_d = RC_EMPTY;
					end else begin
						do_pop   = 1'b1;
						otag_d   = tag_mem_q[ch_m];
						ostat_d  = stat_mem_q[ch_m];
						oext_d   = ext_mem_q[ch_m];
						obytes_d = bytes_mem_q[ch_m];
						// tag mismatch outranks bad status
						if (otag_d != tag_s1)
							code_d = RC_TAG_MISS;
						else if (ostat_d != ok_status_q)
							code_d = RC_BAD_STAT;
					end
				end
				KIND_CLEAR: do_clear = 1'b1;
				default: ;
			endcase
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_head_q  <= '0;
			sub_tail_q  <= '0;
			comp_head_q <= '0;
			comp_tail_q <= '0;
			occ_q       <= '0;
		end else if (do_clear) begin
			sub_head_q  <= '0;
			sub_tail_q  <= '0;
			comp_head_q <= '0;
			comp_tail_q <= '0;
			occ_q       <= '0;
		end else begin
			if (do_sub)
				sub_head_q <= sub_next;
			if (do_post) begin
				occ_q[ct_m] <= (stat_s1 != SLOT_EMPTY);
				comp_tail_q <= comp_tail_next;
			end
			if (do_pop) begin
				occ_q[ch_m] <= 1'b0;
				comp_head_q <= comp_head_next;
				sub_tail_q  <= sub_tail_next;
			end
		end
	end

	// record stores, written only by a post
	always_ff @(posedge clk) begin
		if (do_post) begin
			tag_mem_q[ct_m]   <= tag_s1;
			stat_mem_q[ct_m]  <= stat_s1;
			ext_mem_q[ct_m]   <= ext_s1;
			bytes_mem_q[ct_m] <= bytes_s1;
		end
	end

	// ---------------- result register ----------------
	logic               result_valid_q;
	logic [CODE_W-1:0]  result_code_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [STAT_W-1:0]  out_ext_q;
	logic [BYTES_W-1:0] out_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else
			result_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_code_q <= code_d;
			out_tag_q     <= otag_d;
			out_status_q  <= ostat_d;
			out_ext_q     <= oext_d;
			out_bytes_q   <= obytes_d;
		end
	end

	assign result_valid   = result_valid_q;
	assign result_code    = result_code_q;
	assign out_tag        = out_tag_q;
	assign out_status     = out_status_q;
	assign out_ext_status = out_ext_q;
	assign out_bytes      = out_bytes_q;

	// ---------------- assertions ----------------
	// every accepted request yields a result once it has passed the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 result_valid)
		else $error("accepted request produced no result");

	// an empty take never carries record fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_code == RC_EMPTY) |->
		(out_tag == '0 && out_status == '0 && out_ext_status == '0 && out_bytes == '0))
		else $error("empty take returned record data");

	// a popped record is never an empty-marked slot
	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> out_status != SLOT_EMPTY)
		else $error("popped a slot marked empty");

	// clear leaves every completion slot free and pointers at zero
	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		do_clear |=> (occ_q == '0 && comp_head_q == '0 && comp_tail_q == '0
			&& sub_head_q == '0 && sub_tail_q == '0))
		else $error("clear left ring state behind");

endmodule

// ===== sim/submit_completion_queue_pair_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// submit_completion_queue_pair_test: self-checking bench for the ring pair
// Drives submit, post, take and clear requests through the command port and
// predicts every result with a local model of the two rings. Each result is
// compared field by field against the oldest prediction. The run covers
// several depth and status settings and random idle gaps on the sender side.
// ----------------------------------------------------------------------------
module submit_completion_queue_pair_test;
	import sqp_pkg::*;

	localparam int MAX_DEPTH   = 8;
	localparam int PTR_W       = $clog2(MAX_DEPTH);
	localparam int STALL_LIMIT = 1000;	// cycles with no request and no result
	localparam int DRAIN_TAIL  = 4;		// extra wait after the final drain

	typedef struct {
		kind_t             kind;
		logic [TAG_W-1:0]   tag;
		logic [STAT_W-1:0]  status;
		logic [STAT_W-1:0]  ext;
		logic [BYTES_W-1:0] bytes;
	} ring_req_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [TAG_W-1:0]   tag;
		logic [STAT_W-1:0]  status;
		logic [STAT_W-1:0]  ext;
		logic [BYTES_W-1:0] bytes;
	} ring_result_t;

	// DUT connections
	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [KIND_W-1:0]     kind;
	logic [TAG_W-1:0]      item_tag;
	logic [STAT_W-1:0]     comp_status;
	logic [STAT_W-1:0]     comp_ext_status;
	logic [BYTES_W-1:0]    comp_bytes;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_valid;
	logic [CODE_W-1:0]     result_code;
	logic [TAG_W-1:0]      out_tag;
	logic [STAT_W-1:0]     out_status;
	logic [STAT_W-1:0]     out_ext_status;
	logic [BYTES_W-1:0]    out_bytes;

	// shadow copy of the block: configuration
	logic                  mdl_enable;
	logic [REQ_W-1:0]      mdl_sub_req;
	logic [REQ_W-1:0]      mdl_cq_req;
	logic [STAT_W-1:0]     mdl_ok_code;
	// shadow copy of the block: ring pointers and completion slots
	logic [PTR_W-1:0]      sub_head, sub_tail, cq_head, cq_tail;
	logic [STAT_W-1:0]     cq_status [MAX_DEPTH];
	logic [TAG_W-1:0]      cq_tag    [MAX_DEPTH];
	logic [STAT_W-1:0]     cq_ext    [MAX_DEPTH];
	logic [BYTES_W-1:0]    cq_bytes  [MAX_DEPTH];

	ring_result_t pending_results[$];	// predicted, not yet seen on the port

	bit idle_enable;
	int progress, progress_seen, stall_cycles;
	int fail_count, requests_sent, results_checked;
	int code_tally[6];

	submit_completion_queue_pair #(
		.MAX_RING_DEPTH(MAX_DEPTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.item_tag       (item_tag),
		.comp_status    (comp_status),
		.comp_ext_status(comp_ext_status),
		.comp_bytes     (comp_bytes),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.result_code    (result_code),
		.out_tag        (out_tag),
		.out_status     (out_status),
		.out_ext_status (out_ext_status),
		.out_bytes      (out_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Ring model
	// ------------------------------------------------------------------

	// requested depth -> power of two in 1..MAX_DEPTH, zero selects default
	function automatic int ring_depth(input logic [REQ_W-1:0] req);
		int d, p;
		d = (req == '0) ? int'(DEFAULT_DEPTH) : int'(req);
		if (d > MAX_DEPTH)
			d = MAX_DEPTH;
		p = 1;
		while ((p << 1) <= d)
			p = p << 1;
		return p;
	endfunction

	function automatic logic [PTR_W-1:0] sub_mask();
		return PTR_W'(ring_depth(mdl_sub_req) - 1);
	endfunction

	function automatic logic [PTR_W-1:0] cq_mask();
		return PTR_W'(ring_depth(mdl_cq_req) - 1);
	endfunction

	// clear empties the completion slots but keeps ext status and byte counts
	function automatic void clear_rings();
		sub_head = '0;
		sub_tail = '0;
		cq_head  = '0;
		cq_tail  = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			cq_status[i] = SLOT_EMPTY;
			cq_tag[i]    = '0;
		end
	endfunction

	function automatic void reset_model();
		mdl_enable  = 1'b0;
		mdl_sub_req = REQ_W'(4);
		mdl_cq_req  = REQ_W'(4);
		mdl_ok_code = '0;
		clear_rings();
		for (int i = 0; i < MAX_DEPTH; i++) begin
			cq_ext[i]   = '0;
			cq_bytes[i] = '0;
		end
	endfunction

	// Apply one request to the shadow rings and return the result it yields.
	// Pointers are always masked with the current depth, so a depth change
	// while entries are live just folds the pointers into the smaller ring.
	function automatic ring_result_t ring_request(input ring_req_t rq);
		ring_result_t r;
		logic [PTR_W-1:0] smask, cmask, nxt, idx;
		r      = '0;
		r.code = RC_OK;
		smask  = sub_mask();
		cmask  = cq_mask();
		case (rq.kind)
			KIND_SUBMIT: begin
				if (!mdl_enable) begin
					r.code = RC_NOT_READY;
				end else begin
					// one slot always stays free
					nxt = ((sub_head & smask) + 1'b1) & smask;
					if (nxt == (sub_tail & smask))
						r.code = RC_FULL;
					else
						sub_head = nxt;
				end
			end
			KIND_POST: begin
				// no full check, an occupied slot is simply overwritten
				idx            = cq_tail & cmask;
				cq_tag[idx]    = rq.tag;
				cq_status[idx] = rq.status;
				cq_ext[idx]    = rq.ext;
				cq_bytes[idx]  = rq.bytes;
				cq_tail        = (idx + 1'b1) & cmask;
			end
			KIND_TAKE: begin
				idx = cq_head & cmask;
				if (cq_status[idx] == SLOT_EMPTY) begin
					r.code = RC_EMPTY;
				end else begin
					r.tag          = cq_tag[idx];
					r.status       = cq_status[idx];
					r.ext          = cq_ext[idx];
					r.bytes        = cq_bytes[idx];
					cq_status[idx] = SLOT_EMPTY;
					cq_head        = (idx + 1'b1) & cmask;
					// frees a submit slot even if nothing was submitted
					sub_tail       = ((sub_tail & smask) + 1'b1) & smask;
					// tag mismatch wins over bad status
					if (r.tag != rq.tag)
						r.code = RC_TAG_MISS;
					else if (r.status != mdl_ok_code)
						r.code = RC_BAD_STAT;
				end
			end
			default: clear_rings();
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	function automatic ring_req_t make_req(input kind_t k, input logic [TAG_W-1:0] tag,
			input logic [STAT_W-1:0] st, input logic [STAT_W-1:0] ext,
			input logic [BYTES_W-1:0] bytes);
		ring_req_t rq;
		rq.kind   = k;
		rq.tag    = tag;
		rq.status = st;
		rq.ext    = ext;
		rq.bytes  = bytes;
		return rq;
	endfunction

	// Drive one request and hold it until accepted. busy is looked at on the
	// falling edge; it only moves on rising edges, so that is its value at
	// the next rising edge. Returns just after the accepting edge, start
	// still high so back-to-back requests need no gap.
	task automatic send_request(input ring_req_t rq);
		int gap;
		bit taken;
		gap = 0;
		// rare idle gaps of random length, before about 2 in 100 requests
		if (idle_enable && $urandom_range(99) < 2)
			gap = $urandom_range(1, 5);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		kind            = rq.kind;
		item_tag        = rq.tag;
		comp_status     = rq.status;
		comp_ext_status = rq.ext;
		comp_bytes      = rq.bytes;
		start           = 1'b1;
		taken           = 1'b0;
		while (!taken) begin
			taken = !busy;
			@(posedge clk);
			if (!taken)
				@(negedge clk);
		end
		pending_results.push_back(ring_request(rq));
		requests_sent++;
		progress++;
	endtask

	// stop sending and wait until every predicted result has come back
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// only called with the block idle
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_ENABLE:     mdl_enable  = val[0];
			REG_SUBMIT_DEP: mdl_sub_req = val[REQ_W-1:0];
			REG_COMP_DEP:   mdl_cq_req  = val[REQ_W-1:0];
			default:        mdl_ok_code = val;
		endcase
	endtask

	task automatic set_config(input bit en, input int sreq, input int creq, input int ok);
		wait_drained();
		write_reg(REG_ENABLE, CFG_DATA_W'(en));
		write_reg(REG_SUBMIT_DEP, CFG_DATA_W'(sreq));
		write_reg(REG_COMP_DEP, CFG_DATA_W'(creq));
		write_reg(REG_OK_STATUS, CFG_DATA_W'(ok));
	endtask

	// Random traffic: mostly well-formed post/take pairs whose take tag
	// matches the head record, plus submits, the odd clear and some noise.
	task automatic run_traffic(input int count);
		ring_req_t rq;
		int pick, roll;
		repeat (count) begin
			pick = $urandom_range(99);
			rq = make_req(KIND_SUBMIT, $urandom(), STAT_W'($urandom()),
				STAT_W'($urandom()), $urandom());
			if (pick < 30) begin
				rq.kind = KIND_SUBMIT;
			end else if (pick < 62) begin
				rq.kind = KIND_POST;
				roll = $urandom_range(99);
				if (roll < 70)
					rq.status = mdl_ok_code;
				else if (roll < 75)
					rq.status = SLOT_EMPTY;
			end else if (pick < 94) begin
				rq.kind = KIND_TAKE;
				if ($urandom_range(99) < 85)
					rq.tag = cq_tag[cq_head & cq_mask()];
			end else if (pick < 97) begin
				rq.kind = KIND_CLEAR;
			end else begin
				rq.kind = kind_t'($urandom_range(3));
			end
			send_request(rq);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset state: block disabled, depth 4 on both rings, ok status 0.
	// Covers refused submit, empty take, extreme field values, a posted
	// empty marker, clear while disabled and both error codes at once.
	task automatic test_reset_state();
		send_request(make_req(KIND_SUBMIT, '0, '0, '0, '0));
		send_request(make_req(KIND_TAKE, '0, '0, '0, '0));
		send_request(make_req(KIND_POST, '1, '0, '1, '1));
		send_request(make_req(KIND_TAKE, '1, '0, '0, '0));
		// posted status of all ones leaves the slot reading as empty
		send_request(make_req(KIND_POST, '0, SLOT_EMPTY, '0, '0));
		send_request(make_req(KIND_TAKE, '0, '0, '0, '0));
		send_request(make_req(KIND_CLEAR, '0, '0, '0, '0));
		send_request(make_req(KIND_POST, 32'h0000_00a5, 16'h0005, 16'h1234, 32'd512));
		send_request(make_req(KIND_TAKE, 32'h0000_00a5, '0, '0, '0));
		// wrong tag and wrong status together
		send_request(make_req(KIND_POST, 32'h1111_1111, 16'h0005, 16'h8000, 32'h8000_0000));
		send_request(make_req(KIND_TAKE, 32'h2222_2222, '0, '0, '0));
		send_request(make_req(KIND_POST, 32'h3333_3333, '0, '0, 32'd1));
		send_request(make_req(KIND_TAKE, 32'h4444_4444, '0, '0, '0));
	endtask

	// Enabled: fill the submit ring to full, overrun the completion ring so a
	// live slot is overwritten, take twice, then clear and take from the empty ring.
	task automatic test_enabled_ring();
		set_config(1'b1, 4, 4, 0);
		repeat (4) send_request(make_req(KIND_SUBMIT, $urandom(), '0, '0, '0));
		for (int i = 0; i < 5; i++)
			send_request(make_req(KIND_POST, TAG_W'(i), '0, STAT_W'(i), BYTES_W'(i)));
		send_request(make_req(KIND_TAKE, TAG_W'(4), '0, '0, '0));
		send_request(make_req(KIND_TAKE, TAG_W'(1), '0, '0, '0));
		send_request(make_req(KIND_SUBMIT, '1, '1, '1, '1));
		send_request(make_req(KIND_CLEAR, '1, '1, '1, '1));
		send_request(make_req(KIND_TAKE, '0, '0, '0, '0));
		send_request(make_req(KIND_SUBMIT, '0, '0, '0, '0));
	endtask

	// Walk through depth and status settings without clearing in between,
	// so pointers of the old depth get folded into the new one.
	task automatic test_depth_settings();
		int sreqs[8] = '{0, 1, 2, 5, 8, 9, 255, 7};
		int creqs[8] = '{0, 1, 3, 6, 8, 200, 255, 2};
		int oks[8]   = '{0, 65534, 16'h1234, 0, 7, 65534, 0, 1};
		for (int i = 0; i < 8; i++) begin
			set_config(i != 3, sreqs[i], creqs[i], oks[i]);
			run_traffic(50);
		end
	endtask

	// Longer random run at full depth: idle gaps, a full drain in the
	// middle, a stretch where the sender never idles, then a submit ring of 4.
	task automatic test_random_traffic();
		set_config(1'b1, 8, 8, 16'h00c3);
		run_traffic(100);
		wait_drained();
		run_traffic(50);
		idle_enable = 1'b0;
		run_traffic(100);
		idle_enable = 1'b1;
		set_config(1'b1, 4, 8, 0);
		run_traffic(50);
	endtask

	// ------------------------------------------------------------------
	// Result checker: every strobe must match the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ring_result_t want, got;
		if (arst_n && result_valid) begin
			progress++;
			got = {result_code, out_tag, out_status, out_ext_status, out_bytes};
			if (pending_results.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: result with none expected: code %0d tag %h",
						$realtime, result_code, out_tag);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.code < 6)
					code_tally[got.code]++;
				if (got != want) begin
					if (fail_count < 10)
						$display({"%0t: result %0d mismatch: expected code %0d tag %h ",
							"st %h ext %h bytes %h, got code %0d tag %h st %h ext %h ",
							"bytes %h"}, $realtime, results_checked,
							want.code, want.tag, want.status, want.ext, want.bytes,
							got.code, got.tag, got.status, got.ext, got.bytes);
					fail_count++;
				end
			end
		end
	end

	// watchdog: no request taken and no result seen for too long
	always @(negedge clk) begin
		if (progress != progress_seen) begin
			progress_seen = progress;
			stall_cycles  = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", STALL_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int directed;
		arst_n          = 1'b0;
		start           = 1'b0;
		kind            = KIND_SUBMIT;
		item_tag        = '0;
		comp_status     = '0;
		comp_ext_status = '0;
		comp_bytes      = '0;
		cfg_write       = 1'b0;
		cfg_index       = REG_ENABLE;
		cfg_data        = '0;
		idle_enable     = 1'b1;
		progress        = 0;
		progress_seen   = 0;
		stall_cycles    = 0;
		fail_count      = 0;
		requests_sent   = 0;
		results_checked = 0;
		reset_model();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_enabled_ring();
		directed = requests_sent;
		test_depth_settings();
		test_random_traffic();

		wait_drained();
		repeat (DRAIN_TAIL) @(negedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			fail_count += pending_results.size();
		end

		$display("%0d requests (%0d directed), %0d results checked over 12 settings",
			requests_sent, directed, results_checked);
		$display("codes ok %0d, full %0d, not ready %0d, empty %0d, tag miss %0d, bad %0d",
			code_tally[RC_OK], code_tally[RC_FULL], code_tally[RC_NOT_READY],
			code_tally[RC_EMPTY], code_tally[RC_TAG_MISS], code_tally[RC_BAD_STAT]);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d failures", fail_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
